@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pgs_pkg.sv @@
// Types, constants and helpers shared by the pulse gap receiver files.
`timescale 1ns / 1ps
`default_nettype none
package pgs_pkg;

    // Configuration register indexes and port widths.
    localparam int          CfgIdxW      = 3;
    localparam int          CfgAddrW     = 5;
    localparam int          PDataW       = 32;
    localparam logic [2:0]  CfgSyncMin   = 3'd0;
    localparam logic [2:0]  CfgSyncMax   = 3'd1;
    localparam logic [2:0]  CfgOneMin    = 3'd2;
    localparam logic [2:0]  CfgOneMax    = 3'd3;
    localparam logic [2:0]  CfgZeroMin   = 3'd4;
    localparam logic [2:0]  CfgZeroMax   = 3'd5;
    localparam logic [2:0]  CfgTimeout   = 3'd6;
    localparam logic [2:0]  CfgBlink     = 3'd7;

    // Tick counter saturation value.
    localparam logic [7:0]  TickLimit    = 8'd250;

    // Depth of the queue between classifier and executor.
    localparam int          QueueDepth   = 2;

    // The decoded fields live in the first five bytes of a packet.
    localparam int          DecodeBits   = 40;

    typedef enum logic [1:0] {
        GapOther,
        GapSync,
        GapOne,
        GapZero
    } t_gap_kind;

    typedef struct packed {
        logic      is_tick;
        t_gap_kind kind;
    } t_cls;

    typedef struct packed {
        logic [7:0] sync_gap_min;
        logic [7:0] sync_gap_max;
        logic [7:0] one_gap_min;
        logic [7:0] one_gap_max;
        logic [7:0] zero_gap_min;
        logic [7:0] zero_gap_max;
        logic [7:0] timeout_ticks;
        logic [7:0] blink_ticks;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        sync_gap_min:  8'd70,
        sync_gap_max:  8'd80,
        one_gap_min:   8'd31,
        one_gap_max:   8'd40,
        zero_gap_min:  8'd15,
        zero_gap_max:  8'd23,
        timeout_ticks: 8'd42,
        blink_ticks:   8'd30
    };

    typedef struct packed {
        logic        reading_valid;
        logic [11:0] temperature_code;
        logic [7:0]  humidity_code;
        logic        weak_battery;
        logic        update_indicator;
    } t_result;

    // Open window test: strictly above lo and strictly below hi.
    function automatic logic in_window(input logic [7:0] g, input logic [7:0] lo,
                                       input logic [7:0] hi);
        return (g > lo) && (g < hi);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/pgs_item_if.sv @@
// Input channel: edge or tick items with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface pgs_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] gap_ticks;

    modport source (output valid, output command, output gap_ticks, input ready);
    modport sink   (input valid, input command, input gap_ticks, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pgs_result_if.sv @@
// Output channel: one reading result per item with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface pgs_result_if;
    logic        valid;
    logic        ready;
    logic        reading_valid;
    logic [11:0] temperature_code;
    logic [7:0]  humidity_code;
    logic        weak_battery;
    logic        update_indicator;

    modport source (output valid, output reading_valid, output temperature_code,
                    output humidity_code, output weak_battery, output update_indicator,
                    input ready);
    modport sink   (input valid, input reading_valid, input temperature_code,
                    input humidity_code, input weak_battery, input update_indicator,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/pgs_front.sv @@
// Front end: accepts input items and classifies edge gaps against the windows.
`timescale 1ns / 1ps
`default_nettype none
module pgs_front (
    pgs_item_if.sink      i_item,
    input  pgs_pkg::t_cfg i_cfg,
    input  logic          i_q_ready,
    output logic          o_push,
    output pgs_pkg::t_cls o_cls
);

    logic w_sync;
    logic w_one;
    logic w_zero;

    // Accept whenever the queue has room.
    assign i_item.ready = i_q_ready;
    assign o_push       = i_item.valid && i_q_ready;

    // Window hits for the gap carried with this transfer.
    assign w_sync = pgs_pkg::in_window(i_item.gap_ticks, i_cfg.sync_gap_min,
                                       i_cfg.sync_gap_max);
    assign w_one  = pgs_pkg::in_window(i_item.gap_ticks, i_cfg.one_gap_min,
                                       i_cfg.one_gap_max);
    assign w_zero = pgs_pkg::in_window(i_item.gap_ticks, i_cfg.zero_gap_min,
                                       i_cfg.zero_gap_max);

    // Prioritize sync over one over zero.
    always_comb begin
        o_cls.is_tick = i_item.command;
        if (w_sync) begin
            o_cls.kind = pgs_pkg::GapSync;
        end else if (w_one) begin
            o_cls.kind = pgs_pkg::GapOne;
        end else if (w_zero) begin
            o_cls.kind = pgs_pkg::GapZero;
        end else begin
            o_cls.kind = pgs_pkg::GapOther;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/pgs_queue.sv @@
// Short queue of classified items between the front end and the executor.
`timescale 1ns / 1ps
`default_nettype none
module pgs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pgs_pkg::t_cls i_data,
    output logic          o_ready,
    output logic          o_valid,
    output pgs_pkg::t_cls o_data,
    input  logic          i_pop
);

    localparam int Depth  = pgs_pkg::QueueDepth;
    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    pgs_pkg::t_cls     r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CountW-1:0] r_count;
    logic [PtrW-1:0]   n_wr_ptr;
    logic [PtrW-1:0]   n_rd_ptr;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_ready   = (r_count != CountW'(Depth));
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    // Wrap pointers at the queue depth.
    assign n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
    assign n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);

    // Store pushed entries.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CountW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CountW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/pgs_back.sv @@
// Back end: assembles packets, confirms repeats, runs the tick supervision, registers results.
`timescale 1ns / 1ps
`default_nettype none
module pgs_back #(
    parameter int PACKET_LENGTH = 37
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pgs_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  pgs_pkg::t_cls    i_q_item,
    output logic             o_q_pop,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output pgs_pkg::t_result o_res
);

    // Bits beyond the packet stay zero; the buffer covers the decoded bytes too.
    localparam int BufBits =
        (PACKET_LENGTH > pgs_pkg::DecodeBits) ? PACKET_LENGTH : pgs_pkg::DecodeBits;
    localparam int BufIdxW = $clog2(BufBits);
    localparam int PosW    = $clog2(PACKET_LENGTH + 1);
    localparam int Byte1Hi = BufBits - 9;
    localparam int Byte2Hi = BufBits - 17;
    localparam int Byte3Hi = BufBits - 25;
    localparam int Byte4Hi = BufBits - 33;

    // Receive phases.
    localparam logic [2:0] PhWaitFirst  = 3'd0;
    localparam logic [2:0] PhFirstDone  = 3'd1;
    localparam logic [2:0] PhWaitSecond = 3'd2;
    localparam logic [2:0] PhSecondDone = 3'd3;
    localparam logic [2:0] PhAccepted   = 3'd4;

    logic [BufBits-1:0] r_packet;
    logic [BufBits-1:0] r_first;
    logic [PosW-1:0]    r_bit_pos;
    logic [2:0]         r_phase;
    logic [7:0]         r_ticks;
    logic [11:0]        r_temp;
    logic [7:0]         r_hum;
    logic               r_batt;
    logic               r_ind;
    logic               r_out_valid;
    pgs_pkg::t_result   r_out;

    logic [BufBits-1:0] s_packet;
    logic [PosW-1:0]    s_pos;
    logic [2:0]         s_phase;
    logic [7:0]         s_ticks;

    logic [BufBits-1:0] n_first;
    logic [PosW-1:0]    n_bit_pos;
    logic [2:0]         n_phase;
    logic [7:0]         n_ticks;
    logic [11:0]        n_temp;
    logic [7:0]         n_hum;
    logic               n_batt;
    logic               n_ind;
    logic               w_accept;
    logic               w_room;
    logic [BufIdxW-1:0] w_wr_idx;

    assign o_q_pop     = i_q_valid && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // MSB-first placement of the next bit.
    assign w_room   = (r_bit_pos < PosW'(PACKET_LENGTH));
    assign w_wr_idx = BufIdxW'(BufBits - 1) - BufIdxW'(r_bit_pos);

    // Apply the item: tick count or bit assembly.
    always_comb begin
        s_packet = r_packet;
        s_pos    = r_bit_pos;
        s_phase  = r_phase;
        s_ticks  = r_ticks;
        if (i_q_item.is_tick) begin
            if (r_ticks != pgs_pkg::TickLimit) begin
                s_ticks = r_ticks + 8'd1;
            end
        end else begin
            if (i_q_item.kind == pgs_pkg::GapSync) begin
                s_pos = '0;
            end else if (w_room && (i_q_item.kind == pgs_pkg::GapOne)) begin
                s_packet[w_wr_idx] = 1'b1;
                s_pos              = r_bit_pos + PosW'(1);
            end else if (w_room && (i_q_item.kind == pgs_pkg::GapZero)) begin
                s_packet[w_wr_idx] = 1'b0;
                s_pos              = r_bit_pos + PosW'(1);
            end else begin
                s_pos = '0;
            end
            if (s_pos == PosW'(PACKET_LENGTH)) begin
                if (r_phase == PhWaitFirst) begin
                    s_phase = PhFirstDone;
                end else if (r_phase == PhWaitSecond) begin
                    s_phase = PhSecondDone;
                end
            end
        end
    end

    // Supervise: timeout, copy, compare and decode, indicator end.
    always_comb begin
        n_first   = r_first;
        n_bit_pos = s_pos;
        n_phase   = s_phase;
        n_ticks   = s_ticks;
        n_temp    = r_temp;
        n_hum     = r_hum;
        n_batt    = r_batt;
        n_ind     = r_ind;
        w_accept  = 1'b0;
        if (s_ticks > i_cfg.timeout_ticks) begin
            n_ticks = '0;
            n_phase = PhWaitFirst;
        end else if (s_phase == PhFirstDone) begin
            n_first = s_packet;
            n_phase = PhWaitSecond;
        end else if (s_phase == PhSecondDone) begin
            if (r_first == s_packet) begin
                n_temp   = {s_packet[Byte2Hi -: 8], s_packet[Byte3Hi -: 4]};
                n_hum    = {s_packet[Byte3Hi - 4 -: 4], s_packet[Byte4Hi -: 4]};
                n_batt   = s_packet[Byte1Hi - 4];
                n_ind    = 1'b1;
                n_phase  = PhAccepted;
                w_accept = 1'b1;
            end else begin
                n_phase = PhWaitFirst;
            end
        end else if ((s_phase == PhAccepted) && (s_ticks > i_cfg.blink_ticks)) begin
            n_ind   = 1'b0;
            n_phase = PhWaitFirst;
        end
    end

    // Commit receiver state on each item taken from the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet  <= '0;
            r_first   <= '0;
            r_bit_pos <= '0;
            r_phase   <= PhWaitFirst;
            r_ticks   <= '0;
            r_temp    <= '0;
            r_hum     <= '0;
            r_batt    <= 1'b0;
            r_ind     <= 1'b0;
        end else if (o_q_pop) begin
            r_packet  <= s_packet;
            r_first   <= n_first;
            r_bit_pos <= n_bit_pos;
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_temp    <= n_temp;
            r_hum     <= n_hum;
            r_batt    <= n_batt;
            r_ind     <= n_ind;
        end
    end

    // Output register: load on pop, drop on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out.reading_valid    <= w_accept;
            r_out.temperature_code <= n_temp;
            r_out.humidity_code    <= n_hum;
            r_out.weak_battery     <= n_batt;
            r_out.update_indicator <= n_ind;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/pulse_gap_sensor_packet_receiver_top.sv @@
// Top level of the pulse gap sensor packet receiver with its APB register file.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------------------------
//  i_item    | in  | valid / ready    | command, gap_ticks
//  o_result  | out | valid / ready    | reading_valid, temperature_code, humidity_code,
//            |     |                  | weak_battery, update_indicator
//  apb       | in  | psel/penable     | paddr, pwdata, pwrite -> prdata, pready
//
//  One item per cycle sustained while the output is ready; an item's result passes through the
//  two-entry queue and the output register before it can transfer. The executor updates all
//  receiver state for each popped item, so items flow back to back. Reset is synchronous and
//  clears the control state and configuration, but not the queue storage or output payload.
//  A stalled output holds its result; the queue keeps taking items until it is full.
`timescale 1ns / 1ps
`default_nettype none
module pulse_gap_sensor_packet_receiver_top #(
    parameter int PACKET_LENGTH = 37
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pgs_item_if.sink                     i_item,
    pgs_result_if.source                 o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pgs_pkg::CfgAddrW-1:0] paddr,
    input  logic [pgs_pkg::PDataW-1:0]   pwdata,
    output logic [pgs_pkg::PDataW-1:0]   prdata,
    output logic                         pready
);

    pgs_pkg::t_cfg           r_cfg;
    logic [pgs_pkg::CfgIdxW-1:0] w_reg_idx;
    logic [7:0]              w_rd_byte;
    logic                    w_push;
    pgs_pkg::t_cls           w_push_cls;
    logic                    w_q_ready;
    logic                    w_q_valid;
    pgs_pkg::t_cls           w_q_item;
    logic                    w_q_pop;
    pgs_pkg::t_result        w_res;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[pgs_pkg::CfgAddrW-1:2];

    // Write configuration registers on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pgs_pkg::CfgReset;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                pgs_pkg::CfgSyncMin: r_cfg.sync_gap_min  <= pwdata[7:0];
                pgs_pkg::CfgSyncMax: r_cfg.sync_gap_max  <= pwdata[7:0];
                pgs_pkg::CfgOneMin:  r_cfg.one_gap_min   <= pwdata[7:0];
                pgs_pkg::CfgOneMax:  r_cfg.one_gap_max   <= pwdata[7:0];
                pgs_pkg::CfgZeroMin: r_cfg.zero_gap_min  <= pwdata[7:0];
                pgs_pkg::CfgZeroMax: r_cfg.zero_gap_max  <= pwdata[7:0];
                pgs_pkg::CfgTimeout: r_cfg.timeout_ticks <= pwdata[7:0];
                pgs_pkg::CfgBlink:   r_cfg.blink_ticks   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register.
    always_comb begin
        case (w_reg_idx)
            pgs_pkg::CfgSyncMin: w_rd_byte = r_cfg.sync_gap_min;
            pgs_pkg::CfgSyncMax: w_rd_byte = r_cfg.sync_gap_max;
            pgs_pkg::CfgOneMin:  w_rd_byte = r_cfg.one_gap_min;
            pgs_pkg::CfgOneMax:  w_rd_byte = r_cfg.one_gap_max;
            pgs_pkg::CfgZeroMin: w_rd_byte = r_cfg.zero_gap_min;
            pgs_pkg::CfgZeroMax: w_rd_byte = r_cfg.zero_gap_max;
            pgs_pkg::CfgTimeout: w_rd_byte = r_cfg.timeout_ticks;
            pgs_pkg::CfgBlink:   w_rd_byte = r_cfg.blink_ticks;
            default:             w_rd_byte = '0;
        endcase
    end
    assign prdata = {{(pgs_pkg::PDataW - 8){1'b0}}, w_rd_byte};

    pgs_front u_front (
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cls     (w_push_cls)
    );

    pgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cls),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_item),
        .i_pop   (w_q_pop)
    );

    pgs_back #(
        .PACKET_LENGTH (PACKET_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_res_valid (o_result.valid),
        .i_res_ready (o_result.ready),
        .o_res       (w_res)
    );

    // Drive the result channel payload.
    assign o_result.reading_valid    = w_res.reading_valid;
    assign o_result.temperature_code = w_res.temperature_code;
    assign o_result.humidity_code    = w_res.humidity_code;
    assign o_result.weak_battery     = w_res.weak_battery;
    assign o_result.update_indicator = w_res.update_indicator;

endmodule
`default_nettype wire

@@ rtl/core/pgs_checker.sv @@
// Port-level checker for the receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pgs_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_reading_valid,
    input  wire logic [11:0] i_temperature_code,
    input  wire logic [7:0]  i_humidity_code,
    input  wire logic        i_weak_battery,
    input  wire logic        i_update_indicator
);

    logic [20:0] r_last_held;
    logic        r_last_ind;
    logic [20:0] w_held;

    assign w_held = {i_temperature_code, i_humidity_code, i_weak_battery};

    // Track the fields of the last transferred result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_held <= '0;
            r_last_ind  <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_held <= w_held;
            r_last_ind  <= i_update_indicator;
        end
    end

    `PGS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `PGS_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable({w_held, i_reading_valid, i_update_indicator}), "result changed while stalled")
    `PGS_ASSERT_IMP(a_new_sets_ind, i_clk, i_rst_n, i_out_valid && i_reading_valid, i_update_indicator, "new reading without indicator")
    `PGS_ASSERT_IMP(a_ind_rise, i_clk, i_rst_n, i_out_valid && i_update_indicator && !r_last_ind, i_reading_valid, "indicator rose without a reading")
    `PGS_ASSERT_IMP(a_held_fields, i_clk, i_rst_n, i_out_valid && !i_reading_valid, w_held == r_last_held, "held fields changed without a reading")

endmodule

bind pulse_gap_sensor_packet_receiver_top pgs_checker u_pgs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_reading_valid    (o_result.reading_valid),
    .i_temperature_code (o_result.temperature_code),
    .i_humidity_code    (o_result.humidity_code),
    .i_weak_battery     (o_result.weak_battery),
    .i_update_indicator (o_result.update_indicator)
);
`default_nettype wire
